/* hdl/cmdet_pkg.sv */
// Shared types, constants and control store for the calibrated motion detector.
package cmdet_pkg;

    // Field and register widths
    localparam int MAG_W  = 16;
    localparam int SUM_W  = 23;
    localparam int THR_W  = 20;
    localparam int TIME_W = 32;
    localparam int RAD_W  = 32;
    localparam int HOLD_W = 16;
    localparam int GAIN_W = 4;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam int CAL_SAMPLES_DEF = 100;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd3000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;
    localparam logic [THR_W-1:0]  THR_MAX    = 20'hFFFFF;
    localparam logic [RAD_W-1:0]  ROOT_BIT_INIT = 32'h4000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

    // Sequencer widths
    localparam int STEP_W = 4;
    localparam int LOOP_W = 5;
    localparam int OP_W   = 4;
    localparam int JC_W   = 3;

    localparam logic [LOOP_W-1:0] ROOT_ITERS = 5'd16;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_LOAD = 4'd0;
    localparam logic [OP_W-1:0] OP_SQX  = 4'd1;
    localparam logic [OP_W-1:0] OP_SQY  = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD  = 4'd3;
    localparam logic [OP_W-1:0] OP_ROOT = 4'd4;
    localparam logic [OP_W-1:0] OP_FLAG = 4'd5;
    localparam logic [OP_W-1:0] OP_CAL  = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd7;
    localparam logic [OP_W-1:0] OP_THR  = 4'd8;
    localparam logic [OP_W-1:0] OP_DET  = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd10;

    // Jump conditions
    localparam logic [JC_W-1:0] JC_NEXT  = 3'd0;
    localparam logic [JC_W-1:0] JC_TAKE  = 3'd1;
    localparam logic [JC_W-1:0] JC_LOOP  = 3'd2;
    localparam logic [JC_W-1:0] JC_RUN   = 3'd3;
    localparam logic [JC_W-1:0] JC_MORE  = 3'd4;
    localparam logic [JC_W-1:0] JC_GOTO  = 3'd5;
    localparam logic [JC_W-1:0] JC_DRAIN = 3'd6;

    // Program steps
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_SQX   = 4'd1;
    localparam logic [STEP_W-1:0] ST_SQY   = 4'd2;
    localparam logic [STEP_W-1:0] ST_ADD   = 4'd3;
    localparam logic [STEP_W-1:0] ST_ROOT  = 4'd4;
    localparam logic [STEP_W-1:0] ST_SPLIT = 4'd5;
    localparam logic [STEP_W-1:0] ST_CAL   = 4'd6;
    localparam logic [STEP_W-1:0] ST_DIV   = 4'd7;
    localparam logic [STEP_W-1:0] ST_THR   = 4'd8;
    localparam logic [STEP_W-1:0] ST_DET   = 4'd9;
    localparam logic [STEP_W-1:0] ST_OUT   = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [JC_W-1:0]   jc;
        logic [STEP_W-1:0] target;
        logic              cnt_ld;
        logic [LOOP_W-1:0] cnt_val;
    } uword_t;

    // Conditions sampled by the sequencer
    typedef struct packed {
        logic in_valid;
        logic run;
        logic more;
        logic out_hold;
    } cond_t;

    // Controls handed to the datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            take;
        logic            idle;
    } ctrl_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{op: OP_LOAD, jc: JC_GOTO, target: ST_IDLE, cnt_ld: 1'b0, cnt_val: '0};
        unique case (step)
            ST_IDLE:  w = '{op: OP_LOAD, jc: JC_TAKE,  target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_SQX:   w = '{op: OP_SQX,  jc: JC_NEXT,  target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_SQY:   w = '{op: OP_SQY,  jc: JC_NEXT,  target: ST_IDLE,  cnt_ld: 1'b1,
                            cnt_val: ROOT_ITERS};
            ST_ADD:   w = '{op: OP_ADD,  jc: JC_NEXT,  target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_ROOT:  w = '{op: OP_ROOT, jc: JC_LOOP,  target: ST_ROOT,  cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_SPLIT: w = '{op: OP_FLAG, jc: JC_RUN,   target: ST_DET,   cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_CAL:   w = '{op: OP_CAL,  jc: JC_MORE,  target: ST_OUT,   cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_DIV:   w = '{op: OP_DIV,  jc: JC_NEXT,  target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_THR:   w = '{op: OP_THR,  jc: JC_GOTO,  target: ST_OUT,   cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_DET:   w = '{op: OP_DET,  jc: JC_NEXT,  target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
            ST_OUT:   w = '{op: OP_OUT,  jc: JC_DRAIN, target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
            default:  w = '{op: OP_LOAD, jc: JC_GOTO,  target: ST_IDLE,  cnt_ld: 1'b0,
                            cnt_val: '0};
        endcase
        return w;
    endfunction

endpackage

/* hdl/cmdet_seq.sv */
// Microcoded sequencer: step counter, loop counter and conditional jumps.
module cmdet_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  cmdet_pkg::cond_t    cond,
    output cmdet_pkg::ctrl_t    ctrl
);

    logic [cmdet_pkg::STEP_W-1:0] step_reg, step_next;
    logic [cmdet_pkg::LOOP_W-1:0] cnt_reg, cnt_next;
    cmdet_pkg::uword_t            uw;
    logic [cmdet_pkg::STEP_W-1:0] step_inc;
    logic                         idle;

    assign uw       = cmdet_pkg::ucode(step_reg);
    assign step_inc = step_reg + cmdet_pkg::STEP_W'(1);
    assign idle     = (step_reg == cmdet_pkg::ST_IDLE);

    always_comb
    begin
        step_next = step_inc;
        unique case (uw.jc)
            cmdet_pkg::JC_NEXT:  step_next = step_inc;
            cmdet_pkg::JC_TAKE:  step_next = cond.in_valid ? step_inc : step_reg;
            cmdet_pkg::JC_LOOP:  step_next = (cnt_reg != cmdet_pkg::LOOP_W'(1)) ?
                                             uw.target : step_inc;
            cmdet_pkg::JC_RUN:   step_next = cond.run ? uw.target : step_inc;
            cmdet_pkg::JC_MORE:  step_next = cond.more ? uw.target : step_inc;
            cmdet_pkg::JC_GOTO:  step_next = uw.target;
            cmdet_pkg::JC_DRAIN: step_next = cond.out_hold ? step_reg : uw.target;
            default:             step_next = cmdet_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (uw.cnt_ld)
            cnt_next = uw.cnt_val;
        else if (uw.jc == cmdet_pkg::JC_LOOP)
            cnt_next = cnt_reg - cmdet_pkg::LOOP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cmdet_pkg::ST_IDLE;
            cnt_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign ctrl.op   = uw.op;
    assign ctrl.idle = idle;
    assign ctrl.take = idle && cond.in_valid;

endmodule

/* hdl/calibrated_motion_detector.sv */
// Top level of the calibrated motion detector: datapath and output register.
//
//  channel | direction | handshake          | words
//  --------+-----------+--------------------+----------------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid, in_stall | accel_x, accel_y, time_ms
//  out     | out       | out_valid, out_stall | magnitude, calibrating, motion_event,
//          |           |                    | indicator_on, threshold_value
//
// Each word runs from the idle step that accepts it to the step that loads the output
// register: idle, two squaring steps and an add, sixteen root iterations, two decision
// steps, output; the last calibration word also passes the reciprocal divide by the
// sample count and the threshold step. in_stall stays high from acceptance until the
// result is in the output register, which frees the input while out_stall holds a
// result.
// Reset loads the register defaults and restarts calibration; no clearing pass is needed.
module calibrated_motion_detector #(
    parameter int CAL_SAMPLES = cmdet_pkg::CAL_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cmdet_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmdet_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                accel_x,
    input  logic signed [15:0]                accel_y,
    input  logic [cmdet_pkg::TIME_W-1:0]      time_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cmdet_pkg::MAG_W-1:0]       magnitude,
    output logic                              calibrating,
    output logic                              motion_event,
    output logic                              indicator_on,
    output logic [cmdet_pkg::THR_W-1:0]       threshold_value
);

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);
    localparam logic [CNT_W-1:0] CAL_FULL = CNT_W'(CAL_SAMPLES);

    localparam int MAG_W  = cmdet_pkg::MAG_W;
    localparam int SUM_W  = cmdet_pkg::SUM_W;
    localparam int THR_W  = cmdet_pkg::THR_W;
    localparam int RAD_W  = cmdet_pkg::RAD_W;
    localparam int TIME_W = cmdet_pkg::TIME_W;
    localparam int HOLD_W = cmdet_pkg::HOLD_W;
    localparam int GAIN_W = cmdet_pkg::GAIN_W;
    localparam int SPAN_W = MAG_W + GAIN_W;
    localparam int T_W    = SUM_W + 1;

    // Rounded-up reciprocal of the sample count: exact floor for every SUM_W-bit sum
    localparam int DIV_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
    localparam int QP_W      = DIV_SHIFT + SUM_W;
    localparam logic [QP_W-1:0] RECIP =
        QP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    cmdet_pkg::cond_t cond;
    cmdet_pkg::ctrl_t ctrl;

    // Configuration
    logic [HOLD_W-1:0] hold_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Working registers
    logic [MAG_W-1:0]  ax_reg, ay_reg;
    logic [TIME_W-1:0] now_reg;
    logic [RAD_W-1:0]  rad_reg, prod_reg, root_reg, bit_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic              calib_reg, event_reg;

    // Detector state
    logic [CNT_W-1:0]  cal_count_reg;
    logic [SUM_W-1:0]  cal_sum_reg;
    logic [MAG_W-1:0]  cal_min_reg, cal_max_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              lit_reg;
    logic [TIME_W-1:0] since_reg;

    // Output register
    logic              out_valid_reg;
    logic [MAG_W-1:0]  out_mag_reg;
    logic              out_cal_reg, out_evt_reg, out_ind_reg;
    logic [THR_W-1:0]  out_thr_reg;

    // Datapath signals
    logic [MAG_W-1:0]  ax_abs, ay_abs, mul_a, mag, spread;
    logic [RAD_W-1:0]  product, trial;
    logic              root_fit;
    logic [QP_W-1:0]   quo_prod;
    logic [SPAN_W-1:0] span;
    logic [T_W-1:0]    thr_sum;
    logic              cal_done, det, timed_out;
    logic [TIME_W-1:0] elapsed;
    logic              out_hold;

    cmdet_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    assign cal_done = (cal_count_reg == CAL_FULL);
    assign out_hold = out_valid_reg && out_stall;

    assign cond.in_valid = in_valid;
    assign cond.run      = cal_done;
    assign cond.more     = (cal_count_reg != CAL_LAST);
    assign cond.out_hold = out_hold;

    assign in_stall = !ctrl.idle;

    assign ax_abs = accel_x[15] ? (~$unsigned(accel_x) + MAG_W'(1)) : $unsigned(accel_x);
    assign ay_abs = accel_y[15] ? (~$unsigned(accel_y) + MAG_W'(1)) : $unsigned(accel_y);

    // One shared 16x16 multiplier for both squares
    assign mul_a   = (ctrl.op == cmdet_pkg::OP_SQX) ? ax_reg : ay_reg;
    assign product = RAD_W'(mul_a) * RAD_W'(mul_a);

    assign trial    = root_reg + bit_reg;
    assign root_fit = (rad_reg >= trial);
    assign mag      = root_reg[MAG_W-1:0];

    assign quo_prod = QP_W'(cal_sum_reg) * RECIP;

    assign spread  = (cal_max_reg >= cal_min_reg) ? (cal_max_reg - cal_min_reg) : '0;
    assign span    = SPAN_W'(gain_reg) * SPAN_W'(spread);
    assign thr_sum = T_W'(quo_reg) + T_W'(span);

    assign elapsed   = now_reg - since_reg;
    assign timed_out = (elapsed >= TIME_W'(hold_reg));
    assign det       = (THR_W'(mag) > thr_reg) && !lit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= cmdet_pkg::HOLD_RESET;
            gain_reg <= cmdet_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cmdet_pkg::CFG_HOLD: hold_reg <= cfg_data[HOLD_W-1:0];
                cmdet_pkg::CFG_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload working registers: no reset
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            cmdet_pkg::OP_LOAD:
            begin
                if (ctrl.take)
                begin
                    ax_reg  <= ax_abs;
                    ay_reg  <= ay_abs;
                    now_reg <= time_ms;
                end
            end
            cmdet_pkg::OP_SQX: rad_reg  <= product;
            cmdet_pkg::OP_SQY: prod_reg <= product;
            cmdet_pkg::OP_ADD:
            begin
                rad_reg  <= rad_reg + prod_reg;
                root_reg <= '0;
                bit_reg  <= cmdet_pkg::ROOT_BIT_INIT;
            end
            cmdet_pkg::OP_ROOT:
            begin
                if (root_fit)
                begin
                    rad_reg  <= rad_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            cmdet_pkg::OP_DIV: quo_reg <= quo_prod[DIV_SHIFT +: SUM_W];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg <= '0;
            cal_sum_reg   <= '0;
            cal_min_reg   <= '1;
            cal_max_reg   <= '0;
            thr_reg       <= '0;
            lit_reg       <= 1'b0;
            since_reg     <= '0;
            calib_reg     <= 1'b0;
            event_reg     <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                cmdet_pkg::OP_FLAG:
                begin
                    calib_reg <= !cal_done;
                    event_reg <= 1'b0;
                end
                cmdet_pkg::OP_CAL:
                begin
                    cal_sum_reg   <= cal_sum_reg + SUM_W'(mag);
                    cal_count_reg <= cal_count_reg + CNT_W'(1);
                    if (mag < cal_min_reg)
                        cal_min_reg <= mag;
                    if (mag > cal_max_reg)
                        cal_max_reg <= mag;
                end
                cmdet_pkg::OP_THR:
                    thr_reg <= (thr_sum > T_W'(cmdet_pkg::THR_MAX)) ?
                               cmdet_pkg::THR_MAX : thr_sum[THR_W-1:0];
                cmdet_pkg::OP_DET:
                begin
                    // A fresh detection has zero elapsed time: it only drops at once
                    // when the hold time is zero.
                    if (det)
                    begin
                        lit_reg   <= (hold_reg != '0);
                        since_reg <= now_reg;
                        event_reg <= 1'b1;
                    end
                    else if (lit_reg && timed_out)
                        lit_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.op == cmdet_pkg::OP_OUT && !out_hold)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == cmdet_pkg::OP_OUT && !out_hold)
        begin
            out_mag_reg <= mag;
            out_cal_reg <= calib_reg;
            out_evt_reg <= event_reg;
            out_ind_reg <= lit_reg;
            out_thr_reg <= thr_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign magnitude       = out_mag_reg;
    assign calibrating     = out_cal_reg;
    assign motion_event    = out_evt_reg;
    assign indicator_on    = out_ind_reg;
    assign threshold_value = out_thr_reg;

endmodule

/* hdl/cmdet_checker.sv */
// Port-level checks for the calibrated motion detector and their binding.
module cmdet_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [cmdet_pkg::MAG_W-1:0]       magnitude,
    input logic                              calibrating,
    input logic                              motion_event,
    input logic                              indicator_on,
    input logic [cmdet_pkg::THR_W-1:0]       threshold_value
);

    // An accepted word keeps the input stalled while it is worked on
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after acceptance");

    // A held result keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(magnitude)
            && $stable(threshold_value) && $stable(motion_event))
        else $error("held result changed");

    a_no_event_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibrating |-> !motion_event && !indicator_on)
        else $error("detection during calibration");

    a_event_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motion_event |->
            ({4'b0, magnitude} > threshold_value))
        else $error("event without magnitude above threshold");

    // Once calibration is over the threshold holds its value
    a_thr_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrating |=> !out_valid || $stable(threshold_value))
        else $error("threshold changed after calibration");

endmodule

bind calibrated_motion_detector cmdet_checker u_cmdet_checker (.*);

/* sim/motion_report_checker.sv */
// Report checker for the calibrated motion detector: predicts every report and compares it.
module motion_report_checker
    import cmdet_pkg::*;
#(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [15:0]   accel_x,
    input  logic signed [15:0]   accel_y,
    input  logic [TIME_W-1:0]    time_ms,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [MAG_W-1:0]     magnitude,
    input  logic                 calibrating,
    input  logic                 motion_event,
    input  logic                 indicator_on,
    input  logic [THR_W-1:0]     threshold_value,
    output int                   mismatches,
    output int                   outstanding,
    output int                   detections,
    output logic [THR_W-1:0]     cal_threshold
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             cal;
        logic             evt;
        logic             lit;
        logic [THR_W-1:0] thr;
    } report_t;

    report_t expected_reports[$];

    logic [HOLD_W-1:0] hold_ms;
    logic [GAIN_W-1:0] gain;
    int                cal_taken;
    logic [SUM_W-1:0]  cal_sum;
    logic [MAG_W-1:0]  cal_lo;
    logic [MAG_W-1:0]  cal_hi;
    logic [THR_W-1:0]  trip;
    logic              lit;
    logic [TIME_W-1:0] lit_at;

    // Build the root one bit at a time from the top.
    function automatic logic [MAG_W-1:0] floor_root(input logic [31:0] v);
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] c;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            c = r | (MAG_W'(1) << b);
            if (longint'(c) * longint'(c) <= longint'(v))
                r = c;
        end
        return r;
    endfunction

    function automatic report_t score_sample(input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic [TIME_W-1:0] now);
        report_t           r;
        longint            ax;
        longint            ay;
        longint            spread;
        longint            level;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        ax = x;
        ay = y;
        if (ax < 0)
            ax = -ax;
        if (ay < 0)
            ay = -ay;
        r.mag = floor_root(32'(ax * ax + ay * ay));
        if (cal_taken < CAL_SAMPLES) begin
            r.cal = 1'b1;
            cal_sum = cal_sum + SUM_W'(r.mag);
            if (r.mag < cal_lo)
                cal_lo = r.mag;
            if (r.mag > cal_hi)
                cal_hi = r.mag;
            cal_taken++;
            if (cal_taken >= CAL_SAMPLES) begin
                spread = (cal_hi >= cal_lo) ? longint'(cal_hi) - longint'(cal_lo) : 0;
                level = longint'(cal_sum / CAL_SAMPLES) + longint'(gain) * spread;
                trip = (level > longint'(THR_MAX)) ? THR_MAX : THR_W'(level);
            end
        end else begin
            if (r.mag > trip && !lit) begin
                lit = 1'b1;
                lit_at = now;
                r.evt = 1'b1;
            end
            // wrapping difference, so a lit time just before the wrap still counts
            elapsed = now - lit_at;
            if (lit && elapsed >= TIME_W'(hold_ms))
                lit = 1'b0;
        end
        r.lit = lit;
        r.thr = trip;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t fresh;
        report_t want;
        if (!rst_n) begin
            expected_reports.delete();
            hold_ms = HOLD_RESET;
            gain = GAIN_RESET;
            cal_taken = 0;
            cal_sum = '0;
            cal_lo = '1;
            cal_hi = '0;
            trip = '0;
            lit = 1'b0;
            lit_at = '0;
            mismatches = 0;
            detections = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_HOLD)
                    hold_ms = cfg_data[HOLD_W-1:0];
                else if (cfg_index == CFG_GAIN)
                    gain = cfg_data[GAIN_W-1:0];
            end
            if (in_valid && !in_stall) begin
                fresh = score_sample(accel_x, accel_y, time_ms);
                if (fresh.evt)
                    detections++;
                expected_reports.push_back(fresh);
            end
            if (out_valid && !out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("report word with no sample waiting, magnitude %0d", magnitude);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (magnitude !== want.mag) begin
                        $error("magnitude: expected %0d, actual %0d", want.mag, magnitude);
                        mismatches++;
                    end
                    if (calibrating !== want.cal) begin
                        $error("calibrating: expected %0d, actual %0d", want.cal, calibrating);
                        mismatches++;
                    end
                    if (motion_event !== want.evt) begin
                        $error("motion_event: expected %0d, actual %0d",
                               want.evt, motion_event);
                        mismatches++;
                    end
                    if (indicator_on !== want.lit) begin
                        $error("indicator_on: expected %0d, actual %0d",
                               want.lit, indicator_on);
                        mismatches++;
                    end
                    if (threshold_value !== want.thr) begin
                        $error("threshold_value: expected %0d, actual %0d",
                               want.thr, threshold_value);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_reports.size();
        cal_threshold = trip;
    end

endmodule

/* sim/calibrated_motion_detector_test.sv */
// Top of the calibrated motion detector testbench: clock, reset, stimulus and verdict.
module calibrated_motion_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cmdet_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int SWEEP_PHASES  = 8;
    localparam int SWEEP_ITEMS   = 140;

    // indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [15:0]   accel_x;
    logic signed [15:0]   accel_y;
    logic [TIME_W-1:0]    time_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [MAG_W-1:0]     magnitude;
    logic                 calibrating;
    logic                 motion_event;
    logic                 indicator_on;
    logic [THR_W-1:0]     threshold_value;

    int                   mismatches;
    int                   outstanding;
    int                   detections;
    logic [THR_W-1:0]     cal_threshold;

    int                   idle_pct;
    int                   stall_pct;
    int                   phase_no;
    int                   samples_sent;
    int                   trip_level;
    int                   hold_now;
    int                   cycle_count;
    logic [TIME_W-1:0]    clock_ms;
    int                   hold_plan [SWEEP_PHASES];

    calibrated_motion_detector dut (.*);

    motion_report_checker #(.CAL_SAMPLES(CAL_SAMPLES_DEF)) report_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Present one word and hold it until taken; valid stays high on return.
    task automatic send(input int x, input int y, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        accel_x <= 16'(x);
        accel_y <= 16'(y);
        time_ms <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Rotate through the idle and stall patterns, one per phase.
    task automatic begin_phase();
        case (phase_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 21; stall_pct = 21; end
        endcase
        phase_no++;
    endtask

    task automatic set_hold(input int h);
        write_reg(CFG_HOLD, CFG_W'(h));
        hold_now = h;
    endtask

    task automatic set_gain(input int g);
        write_reg(CFG_GAIN, (CFG_W'($urandom) << GAIN_W) | CFG_W'(g));
    endtask

    task automatic calib_samples(input int n);
        repeat (n)
            send(int'($urandom_range(2000)) - 1000, int'($urandom_range(2000)) - 1000,
                 $urandom);
    endtask

    // Mostly below, above or right at the threshold, with some raw noise.
    task automatic sweep_sample();
        int pick;
        int bound;
        int a;
        int x;
        int y;
        int tmp;
        pick = $urandom_range(99);
        if (pick < 35) begin
            bound = trip_level * 7 / 10;
            x = int'($urandom_range(2 * bound)) - bound;
            y = int'($urandom_range(2 * bound)) - bound;
        end else if (pick < 70) begin
            a = $urandom_range(32768, trip_level + 1);
            x = $urandom_range(1) ? -a : a;
            y = $urandom;
        end else if (pick < 85) begin
            a = trip_level + int'($urandom_range(2)) - 1;
            x = $urandom_range(1) ? -a : a;
            y = 0;
        end else begin
            x = $urandom;
            y = $urandom;
        end
        if ($urandom_range(1)) begin
            tmp = x;
            x = y;
            y = tmp;
        end
        if ($urandom_range(19) == 0)
            clock_ms = $urandom;
        else
            clock_ms += $urandom_range(hold_now / 4 + 2);
        send(x, y, clock_ms);
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d reports pending",
                 cycle_count, outstanding);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        accel_x = '0;
        accel_y = '0;
        time_ms = '0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        phase_no = 0;
        samples_sent = 0;
        hold_now = HOLD_RESET;
        clock_ms = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Calibration, spread kept small so later samples can cross the threshold.
        begin_phase();
        set_gain(15);
        set_hold(0);
        send(0, 0, 32'd0);
        send(-1000, 1000, 32'hFFFF_FFFF);
        send(1000, -1000, $urandom);
        send(-1, 0, $urandom);
        send(0, 1, $urandom);
        calib_samples(35);
        settle();
        begin_phase();
        set_gain(0);
        calib_samples(30);
        settle();
        begin_phase();
        set_gain($urandom_range(15));
        calib_samples(CAL_SAMPLES_DEF - 70);
        settle();
        trip_level = int'(cal_threshold);

        // Equal compare, detection while lit, expiry, wrap of the clock.
        begin_phase();
        set_hold(5);
        send(trip_level, 0, 32'd1000);
        send(trip_level + 1, 0, 32'd1001);
        send(-32768, -32768, 32'd1002);
        send(32767, 32767, 32'd1003);
        send(0, 0, 32'd1006);
        send(-32768, 32767, 32'd1007);
        send(1, -1, 32'hFFFF_FFFE);
        send(0, -(trip_level + 1), 32'hFFFF_FFFF);
        send(-1, -1, 32'd2);
        send(-32768, 0, 32'd4);
        settle();

        // Zero hold: light and drop on the same sample.
        begin_phase();
        set_hold(0);
        send(trip_level + 1, 0, 32'd10);
        send(0, trip_level, 32'd11);
        send(-32768, -32768, 32'd11);
        settle();

        hold_plan = '{65535, 1, 0, 40, 3000, 7, $urandom_range(65535), 250};
        clock_ms = 32'hFFFF_0000;
        for (int p = 0; p < SWEEP_PHASES; p++) begin
            begin_phase();
            set_hold(hold_plan[p]);
            if (p == 0) begin
                write_reg(CFG_SPARE_LO, CFG_W'($urandom));
                write_reg(CFG_SPARE_HI, CFG_W'($urandom));
            end
            repeat (SWEEP_ITEMS) sweep_sample();
            settle();
        end

        $display("Sent %0d samples over %0d phases: %0d calibration, threshold %0d",
                 samples_sent, phase_no, CAL_SAMPLES_DEF, trip_level);
        $display("Saw %0d predicted motion events across hold times 0 to 65535",
                 detections);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/cmdet_pkg.sv
hdl/cmdet_seq.sv
hdl/calibrated_motion_detector.sv
hdl/cmdet_checker.sv
sim/motion_report_checker.sv
sim/calibrated_motion_detector_test.sv
